FILE: hdl/rdwr_pkg.sv
// Shared types and constants for the random draw without replacement block.
`timescale 1ns / 1ps

package rdwr_pkg;

    localparam int RAND_W = 32;
    localparam int IDX_W  = 8;
    localparam int CFG_W  = 9;
    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RAND_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_DIV,
        S_RD_POS,
        S_RD_LAST,
        S_DONE
    } state_t;

endpackage

FILE: hdl/random_draw_without_replacement_core.sv
// Random draw without replacement: shuffle list, modulo unit and draw sequencer.
//
//  channel  | signals                                 | direction
//  ---------+-----------------------------------------+----------
//  cfg      | cfg_valid, cfg_ready, message_count     | in
//  in       | in_valid, in_ready, random_word         | in
//  out      | out_valid, out_ready, drawn_index,      | out
//           | refilled, pool_empty                    |
//
//  A draw from a non-empty list takes 32 steps of the restoring modulo unit (one
//  quotient bit per cycle), then reads the picked and the last entry on the read
//  port of the list memory and writes the last entry into the picked slot on the
//  write port. A draw that finds the list empty first refills it, one entry per
//  cycle. An empty pool answers without touching the list.
//  Reset clears the sequencer, counts and output valid register; the list memory is not
//  cleared, since a refill always writes it before any read.
//  A stalled output holds the block in its last step until the result is taken.
`timescale 1ns / 1ps

module random_draw_without_replacement_core
    import rdwr_pkg::*;
#(
    parameter int MAX_ITEMS = 256
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  message_count,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [RAND_W-1:0] random_word,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [IDX_W-1:0]  drawn_index,
    output logic              refilled,
    output logic              pool_empty
);

    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;

    // List storage
    logic [IDX_W-1:0] list_mem [MAX_ITEMS];

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  msg_reg, msg_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     fill_reg, fill_next;
    logic [RAND_W-1:0] word_reg, word_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              refill_flag_reg, refill_flag_next;
    logic              empty_flag_reg, empty_flag_next;
    logic [IDX_W-1:0]  picked_reg, picked_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  drawn_index_reg, drawn_index_next;
    logic              refilled_reg, refilled_next;
    logic              pool_empty_reg, pool_empty_next;

    logic [IDX_W-1:0]  rd_data_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [IDX_W-1:0]  mem_wdata;

    logic [CW-1:0]     pool_n;
    logic [CW-1:0]     last_full;
    logic [AW-1:0]     pos_idx;
    logic [AW-1:0]     last_idx;
    logic [CW:0]       trial;
    logic [CW:0]       trial_diff;

    // Saturate the configured pool size to the list depth
    always_comb
    begin
        if (CMP_W'(msg_reg) > CMP_W'(MAX_ITEMS))
            pool_n = CW'(MAX_ITEMS);
        else
            pool_n = CW'(msg_reg);
    end

    assign last_full  = count_reg - CW'(1);
    assign last_idx   = last_full[AW-1:0];
    assign pos_idx    = rem_reg[AW-1:0];

    // One restoring modulo step: shift in the next dividend bit, subtract if it fits
    assign trial      = {rem_reg, word_reg[RAND_W-1]};
    assign trial_diff = trial - {1'b0, count_reg};

    assign in_ready    = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready   = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign drawn_index = drawn_index_reg;
    assign refilled    = refilled_reg;
    assign pool_empty  = pool_empty_reg;

    // Sequencer: next state, datapath and memory controls
    always_comb
    begin
        state_next       = state_reg;
        msg_next         = msg_reg;
        count_next       = count_reg;
        fill_next        = fill_reg;
        word_next        = word_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        refill_flag_next = refill_flag_reg;
        empty_flag_next  = empty_flag_reg;
        picked_next      = picked_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        drawn_index_next = drawn_index_reg;
        refilled_next    = refilled_reg;
        pool_empty_next  = pool_empty_reg;
        rd_en            = 1'b0;
        rd_addr          = pos_idx;
        mem_we           = 1'b0;
        mem_waddr        = pos_idx;
        mem_wdata        = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    msg_next   = message_count;
                    count_next = '0;
                end
                else if (in_valid)
                begin
                    word_next        = random_word;
                    rem_next         = '0;
                    step_next        = '0;
                    refill_flag_next = 1'b0;
                    empty_flag_next  = 1'b0;
                    fill_next        = '0;
                    if (pool_n == '0)
                    begin
                        empty_flag_next = 1'b1;
                        state_next      = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        refill_flag_next = 1'b1;
                        state_next       = S_FILL;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end

            // Write index i into slot i, one entry per cycle
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_reg;
                mem_wdata = IDX_W'(fill_reg);
                if (CW'(fill_reg) == pool_n - CW'(1))
                begin
                    count_next = pool_n;
                    state_next = S_DIV;
                end
                else
                begin
                    fill_next = fill_reg + AW'(1);
                end
            end

            S_DIV:
            begin
                if (!trial_diff[CW])
                    rem_next = trial_diff[CW-1:0];
                else
                    rem_next = trial[CW-1:0];
                word_next = {word_reg[RAND_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                    state_next = S_RD_POS;
            end

            S_RD_POS:
            begin
                rd_en      = 1'b1;
                rd_addr    = pos_idx;
                state_next = S_RD_LAST;
            end

            S_RD_LAST:
            begin
                picked_next = rd_data_reg;
                rd_en       = 1'b1;
                rd_addr     = last_idx;
                state_next  = S_DONE;
            end

            // Hand out the item and, unless the pool is empty, move last entry into the drawn slot
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (empty_flag_reg)
                    begin
                        drawn_index_next = '0;
                        refilled_next    = 1'b0;
                        pool_empty_next  = 1'b1;
                    end
                    else
                    begin
                        drawn_index_next = picked_reg;
                        refilled_next    = refill_flag_reg;
                        pool_empty_next  = 1'b0;
                        mem_we           = 1'b1;
                        mem_waddr        = pos_idx;
                        mem_wdata        = rd_data_reg;
                        count_next       = last_full;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            msg_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            msg_reg       <= msg_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and result registers
    always_ff @(posedge clk)
    begin
        fill_reg        <= fill_next;
        word_reg        <= word_next;
        rem_reg         <= rem_next;
        step_reg        <= step_next;
        refill_flag_reg <= refill_flag_next;
        empty_flag_reg  <= empty_flag_next;
        picked_reg      <= picked_next;
        drawn_index_reg <= drawn_index_next;
        refilled_reg    <= refilled_next;
        pool_empty_reg  <= pool_empty_next;
    end

    // List memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            list_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= list_mem[rd_addr];
    end

endmodule

FILE: hdl/rdwr_checker.sv
// Port-level checks for the random draw core and their bind.
`timescale 1ns / 1ps

module rdwr_checker
    import rdwr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [CFG_W-1:0]  message_count,
    input logic              in_valid,
    input logic              in_ready,
    input logic [RAND_W-1:0] random_word,
    input logic              out_valid,
    input logic              out_ready,
    input logic [IDX_W-1:0]  drawn_index,
    input logic              refilled,
    input logic              pool_empty
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drawn_index)
            && $stable(refilled) && $stable(pool_empty))
        else $error("stalled result item changed");

    // Take one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a draw is in progress");

    // An empty pool draws nothing and never refills
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pool_empty |-> drawn_index == '0 && !refilled)
        else $error("empty pool item carries a draw");

    // Config is taken only while no draw is in progress
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !cfg_ready)
        else $error("config port open during a draw");

endmodule

bind random_draw_without_replacement_core rdwr_checker u_rdwr_checker (.*);

FILE: bench/testbench.sv
// Self-checking testbench for the random draw without replacement core.
`timescale 1ns / 1ps

module testbench;
    import rdwr_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int POOL_MAX      = 256;
    localparam int TOTAL_WORDS   = 1750;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 60;

    typedef struct packed {
        logic [IDX_W-1:0] drawn_index;
        logic             refilled;
        logic             pool_empty;
    } draw_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  message_count = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [RAND_W-1:0] random_word = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [IDX_W-1:0]  drawn_index;
    logic              refilled;
    logic              pool_empty;

    // Shadow copy of the block state
    logic [IDX_W-1:0]  shuffle_list [POOL_MAX];
    int unsigned       left_in_round = 0;
    int unsigned       pool_setting = 0;

    logic [RAND_W-1:0] word_queue [$];
    draw_result_t      pending_draws [$];
    int unsigned       words_queued = 0;
    int unsigned       words_accepted = 0;
    int unsigned       cfg_writes = 0;
    int unsigned       mismatches = 0;
    int unsigned       quiet_cycles = 0;
    logic              word_taken = 1'b0;

    int unsigned       burst_left = 1;
    int unsigned       gap_left = 0;
    logic              hold_off_req = 1'b0;
    int unsigned       hold_count = 0;
    logic              rx_stalling = 1'b0;
    int unsigned       rx_run_left = 0;

    random_draw_without_replacement_core #(
        .MAX_ITEMS(POOL_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .message_count(message_count),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .random_word  (random_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drawn_index  (drawn_index),
        .refilled     (refilled),
        .pool_empty   (pool_empty)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Compute the result of one draw and advance the shadow list
    function automatic draw_result_t predict_draw(input logic [RAND_W-1:0] word);
        draw_result_t res;
        int unsigned  n;
        int unsigned  slot;
        res = '0;
        n = (pool_setting > POOL_MAX) ? POOL_MAX : pool_setting;
        if (n == 0)
        begin
            res.pool_empty = 1'b1;
            return res;
        end
        if (left_in_round == 0 || left_in_round > POOL_MAX)
        begin
            for (int i = 0; i < n; i++)
                shuffle_list[i] = IDX_W'(i);
            left_in_round = n;
            res.refilled = 1'b1;
        end
        slot = word % left_in_round;
        res.drawn_index = shuffle_list[slot];
        shuffle_list[slot] = shuffle_list[left_in_round - 1];
        left_in_round = left_in_round - 1;
        return res;
    endfunction

    // Monitor: check results, track register writes, predict accepted draws
    always @(posedge clk)
    begin : monitor
        draw_result_t want;
        if (!rst_n)
        begin
            word_taken <= 1'b0;
        end
        else
        begin
            word_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (pending_draws.size() == 0)
                begin
                    $display("%0t: unexpected item: drawn_index %0d refilled %0b pool_empty %0b",
                             $time, drawn_index, refilled, pool_empty);
                    mismatches++;
                end
                else
                begin
                    want = pending_draws.pop_front();
                    if (drawn_index !== want.drawn_index)
                    begin
                        $display("%0t: drawn_index expected %0d, got %0d",
                                 $time, want.drawn_index, drawn_index);
                        mismatches++;
                    end
                    if (refilled !== want.refilled)
                    begin
                        $display("%0t: refilled expected %0b, got %0b",
                                 $time, want.refilled, refilled);
                        mismatches++;
                    end
                    if (pool_empty !== want.pool_empty)
                    begin
                        $display("%0t: pool_empty expected %0b, got %0b",
                                 $time, want.pool_empty, pool_empty);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                pool_setting = message_count;
                left_in_round = 0;
                cfg_writes++;
            end
            if (in_valid && in_ready)
            begin
                pending_draws = {pending_draws, predict_draw(random_word)};
                words_accepted++;
            end
        end
    end

    // Driver: offer queued words in bursts separated by random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !word_taken))
        begin
            if (in_valid)
            begin
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 80);
                end
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (word_queue.size() > 0)
            begin
                in_valid <= 1'b1;
                random_word <= word_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: alternate ready and stall runs; hold off once for a long stretch
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_off_req && hold_count < HOLD_CYCLES)
        begin
            hold_count++;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_run_left == 0)
            begin
                rx_stalling = !rx_stalling;
                rx_run_left = rx_stalling ? $urandom_range(1, 25) : $urandom_range(1, 300);
            end
            rx_run_left--;
            out_ready <= !rx_stalling;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("random_draw_without_replacement_core test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_word(input logic [RAND_W-1:0] word);
        word_queue = {word_queue, word};
        words_queued++;
    endtask

    // Wait until every queued word is drawn and its result has come back
    task automatic wait_idle();
        while (words_accepted != words_queued || pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_pool_size(input logic [CFG_W-1:0] size);
        int unsigned target;
        wait_idle();
        target = cfg_writes + 1;
        @(negedge clk);
        cfg_valid <= 1'b1;
        message_count <= size;
        wait (cfg_writes == target);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        int unsigned       pick;
        int unsigned       size;
        int unsigned       draws;
        logic [RAND_W-1:0] word;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty pool straight out of reset
        queue_word(32'h0);

        // single entry: every draw refills
        write_pool_size(1);
        queue_word(32'h0);
        queue_word(32'hFFFF_FFFF);

        write_pool_size(2);
        queue_word(32'h0);
        queue_word(32'hFFFF_FFFF);
        queue_word(32'h1);

        // full pool with extreme and alternating words
        write_pool_size(256);
        queue_word(32'h0);
        queue_word(32'hFFFF_FFFF);
        queue_word(32'h5555_5555);
        queue_word(32'hAAAA_AAAA);
        queue_word(32'd255);
        queue_word(32'd256);

        // oversize pool saturates to the list depth
        write_pool_size(9'h1FF);
        queue_word(32'h7FFF_FFFF);
        queue_word(32'h8000_0000);
        queue_word(32'h1234_5678);

        // a write in mid round empties the list
        write_pool_size(3);
        queue_word(32'd2);
        write_pool_size(3);
        queue_word(32'd1);

        write_pool_size(0);
        queue_word(32'h0);
        queue_word(32'hFFFF_FFFF);

        // long receiver hold-off while the sender keeps offering
        write_pool_size(40);
        repeat (60) queue_word($urandom);
        hold_off_req = 1'b1;

        // random phases of pool size and draws
        while (words_queued < TOTAL_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                size = 0;
            else if (pick < 55)
                size = $urandom_range(1, 16);
            else if (pick < 80)
                size = $urandom_range(17, 64);
            else if (pick < 88)
                size = $urandom_range(65, 255);
            else if (pick < 95)
                size = 256;
            else
                size = $urandom_range(257, 511);
            write_pool_size(CFG_W'(size));
            if (size == 0)
                draws = $urandom_range(1, 4);
            else
                draws = $urandom_range(1, ((size > POOL_MAX) ? POOL_MAX : size) * 2 + 2);
            if (draws > 300)
                draws = 300;
            if (draws > TOTAL_WORDS - words_queued)
                draws = TOTAL_WORDS - words_queued;
            repeat (draws)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    word = $urandom;
                else if (pick < 8)
                    word = $urandom_range(0, 600);
                else
                    word = 32'hFFFF_FFFF - $urandom_range(0, 600);
                queue_word(word);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("random_draw_without_replacement_core test passed");
        else
            $display("random_draw_without_replacement_core test failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/rdwr_pkg.sv
hdl/random_draw_without_replacement_core.sv
hdl/rdwr_checker.sv
bench/testbench.sv
